// ===== sv/lidar_polar_to_cartesian_top_assert.svh =====
// ----------------------------------------------------------------------------
// lidar polar to cartesian assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LIDAR_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_TOP_ASSERT_SVH

// same-cycle implication
`define LP2C_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lp2c assertion failed");

// next-cycle implication
`define LP2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lp2c assertion failed");

`endif

// ===== sv/lp2c_pkg.sv =====
// ----------------------------------------------------------------------------
// lp2c_pkg
// widths, constants and item sideband type of the polar to cartesian block
// ----------------------------------------------------------------------------
`default_nettype none

package lp2c_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int DIST_W = 16;
  localparam int ANG_W  = 15;
  localparam int POS_W  = 17;
  localparam int IDX_W  = 10;
  localparam int QUAD_W = 2;
  localparam int REM_W  = 13;

  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;

  // remainder to radians: z = r*ZA + floor((r*ZB + ZHALF) / 5760)
  // with pi/2 * 2^30 = 5760*ZA + ZB
  localparam int ZA_W     = 19;
  localparam int ZB_W     = 12;
  localparam int ZA       = 292817;
  localparam int ZB       = 3793;
  localparam int ZHALF    = 2880;
  localparam int P1_W     = 32;
  localparam int P2_W     = 25;
  // floor(w / 5760) = ((w >> 7) * RECIP_M) >> 24, exact for w below 2^25
  localparam int PRE_SH   = 7;
  localparam int U_W      = P2_W - PRE_SH;
  localparam int RECIP_W  = 19;
  localparam int RECIP_M  = 372828;
  localparam int RECIP_SH = 24;
  localparam int M_W      = U_W + RECIP_W;

  localparam int CORDIC_STEPS = 24;
  localparam int XY_W         = 34;
  localparam int Z_W          = 34;
  localparam logic [31:0] GAIN_INV = 32'h26DD3B6A;

  localparam int Q16_W  = 18;
  localparam int PROD_W = 35;

  typedef struct packed {
    logic              keep;
    logic [IDX_W-1:0]  index;
    logic              last;
    logic [DIST_W-1:0] distance;
    logic [QUAD_W-1:0] quad;
  } side_t;

  // atan(2^-step) in q30, truncated
  function automatic logic [31:0] atan_q30(input int step);
    logic [31:0] a;
    case (step)
      0:       a = 32'h3243F6A8;
      1:       a = 32'h1DAC6705;
      2:       a = 32'h0FADBAFC;
      3:       a = 32'h07F56EA6;
      4:       a = 32'h03FEAB76;
      5:       a = 32'h01FFD55B;
      6:       a = 32'h00FFFAAA;
      7:       a = 32'h007FFF55;
      8:       a = 32'h003FFFEA;
      9:       a = 32'h001FFFFD;
      10:      a = 32'h000FFFFF;
      11:      a = 32'h0007FFFF;
      12:      a = 32'h0003FFFF;
      13:      a = 32'h0001FFFF;
      14:      a = 32'h0000FFFF;
      15:      a = 32'h00007FFF;
      16:      a = 32'h00003FFF;
      17:      a = 32'h00001FFF;
      18:      a = 32'h00000FFF;
      19:      a = 32'h000007FF;
      20:      a = 32'h000003FF;
      21:      a = 32'h000001FF;
      22:      a = 32'h000000FF;
      23:      a = 32'h0000007F;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lp2c_front.sv =====
// ----------------------------------------------------------------------------
// lp2c_front
// point counter, angle reduction to quadrant and remainder, remainder to radians
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_polar_to_cartesian_top_assert.svh"

module lp2c_front #(
  parameter int MAX_POINTS = lp2c_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lp2c_pkg::DIST_W-1:0]       in_distance,
  input  logic [lp2c_pkg::ANG_W-1:0]        in_angle,
  input  logic                              in_last_in_scan,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [lp2c_pkg::Z_W-1:0]   dn_z,
  output lp2c_pkg::side_t                   dn_side
);
  import lp2c_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic             v0_r, v1_r, v2_r, v3_r;
  logic             rdy0, rdy1, rdy2, rdy3;
  logic             accept;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ANG_W-1:0]  ang_wrap;
  logic [QUAD_W-1:0] quad_nxt;
  logic [REM_W-1:0]  rem_nxt;
  side_t             side_nxt;

  logic [REM_W-1:0]  rem0_r;
  side_t             side0_r, side1_r, side2_r, side3_r;
  logic [P1_W-1:0]   p1_nxt, p1_r, p1b_r;
  logic [P2_W-1:0]   p2_nxt, p2_r;
  logic [M_W-1:0]    m_nxt, m_r;
  logic signed [Z_W-1:0] z_nxt, z3_r;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;
  assign accept   = in_valid && rdy0;

  always_comb begin
    ang_wrap = (in_angle >= ANG_W'(FULL_TURN)) ? in_angle - ANG_W'(FULL_TURN) : in_angle;
    if (ang_wrap >= ANG_W'(3 * QUARTER_TURN)) begin
      quad_nxt = 2'd3;
      rem_nxt  = REM_W'(ang_wrap - ANG_W'(3 * QUARTER_TURN));
    end else if (ang_wrap >= ANG_W'(2 * QUARTER_TURN)) begin
      quad_nxt = 2'd2;
      rem_nxt  = REM_W'(ang_wrap - ANG_W'(2 * QUARTER_TURN));
    end else if (ang_wrap >= ANG_W'(QUARTER_TURN)) begin
      quad_nxt = 2'd1;
      rem_nxt  = REM_W'(ang_wrap - ANG_W'(QUARTER_TURN));
    end else begin
      quad_nxt = 2'd0;
      rem_nxt  = REM_W'(ang_wrap);
    end
    side_nxt.keep     = (in_distance != '0) && (cnt_r < CNT_MAX);
    side_nxt.index    = IDX_W'(cnt_r);
    side_nxt.last     = in_last_in_scan;
    side_nxt.distance = in_distance;
    side_nxt.quad     = quad_nxt;
  end

  // count holds once the scan is full, clears after the closing item
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_in_scan) begin
        cnt_nxt = '0;
      end else if (side_nxt.keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    p1_nxt = P1_W'(rem0_r) * P1_W'(ZA);
    p2_nxt = P2_W'(rem0_r) * P2_W'(ZB) + P2_W'(ZHALF);
    m_nxt  = M_W'(p2_r[P2_W-1:PRE_SH]) * M_W'(RECIP_M);
    z_nxt  = $signed(Z_W'(p1b_r) + Z_W'(m_r[M_W-1:RECIP_SH]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      rem0_r  <= rem_nxt;
      side0_r <= side_nxt;
    end
    if (rdy1) begin
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      side1_r <= side0_r;
    end
    if (rdy2) begin
      p1b_r   <= p1_r;
      m_r     <= m_nxt;
      side2_r <= side1_r;
    end
    if (rdy3) begin
      z3_r    <= z_nxt;
      side3_r <= side2_r;
    end
  end

  assign dn_valid = v3_r;
  assign dn_z     = z3_r;
  assign dn_side  = side3_r;

  `LP2C_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX)
  `LP2C_ASSERT_NEXT(a_cnt_scan_restart, accept && in_last_in_scan, cnt_r == '0)

endmodule

`default_nettype wire

// ===== sv/lp2c_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lp2c_cordic_cell
// one rotation-mode cordic iteration with its own stage register
// ----------------------------------------------------------------------------
`default_nettype none

module lp2c_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [lp2c_pkg::XY_W-1:0] up_x,
  input  logic signed [lp2c_pkg::XY_W-1:0] up_y,
  input  logic signed [lp2c_pkg::Z_W-1:0]  up_z,
  input  lp2c_pkg::side_t                  up_side,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [lp2c_pkg::XY_W-1:0] dn_x,
  output logic signed [lp2c_pkg::XY_W-1:0] dn_y,
  output logic signed [lp2c_pkg::Z_W-1:0]  dn_z,
  output lp2c_pkg::side_t                  dn_side
);
  import lp2c_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = $signed(Z_W'(atan_q30(STEP)));

  logic                   v_r;
  logic signed [XY_W-1:0] dx, dy, x_nxt, y_nxt, x_r, y_r;
  logic signed [Z_W-1:0]  z_nxt, z_r;
  side_t                  side_r;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    dx = up_y >>> STEP;
    dy = up_x >>> STEP;
    if (!up_z[Z_W-1]) begin
      x_nxt = up_x - dx;
      y_nxt = up_y + dy;
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + dx;
      y_nxt = up_y - dy;
      z_nxt = up_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = v_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;
  assign dn_side  = side_r;

endmodule

`default_nettype wire

// ===== sv/lp2c_back.sv =====
// ----------------------------------------------------------------------------
// lp2c_back
// q16 rounding, quadrant mapping, scaling by distance and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lp2c_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [lp2c_pkg::XY_W-1:0]  up_x,
  input  logic signed [lp2c_pkg::XY_W-1:0]  up_y,
  input  lp2c_pkg::side_t                   up_side,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_point_valid,
  output logic signed [lp2c_pkg::POS_W-1:0] out_pos_x,
  output logic signed [lp2c_pkg::POS_W-1:0] out_pos_y,
  output logic [lp2c_pkg::IDX_W-1:0]        out_point_index,
  output logic                              out_scan_end
);
  import lp2c_pkg::*;

  localparam logic signed [XY_W-1:0]   RND    = XY_W'(8192);
  localparam logic signed [XY_W-1:0]   LIM_HI = XY_W'(65536);
  localparam logic signed [XY_W-1:0]   LIM_LO = -XY_W'(65536);
  localparam logic signed [PROD_W-1:0] TRUNC_ADJ = PROD_W'(65535);

  // round to q16 toward minus infinity after the half offset, then clamp
  function automatic logic signed [Q16_W-1:0] to_q16(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + RND) >>> 14;
    if (t > LIM_HI) begin
      t = LIM_HI;
    end else if (t < LIM_LO) begin
      t = LIM_LO;
    end
    return Q16_W'(t);
  endfunction

  logic                    vb0_r, vb1_r, out_valid_r;
  logic                    rdy0, rdy1, rdy2;
  logic signed [Q16_W-1:0] s, c, sn_nxt, cs_nxt, sn_r, cs_r;
  side_t                   side0_r, side1_r;
  logic signed [DIST_W:0]  dist_s;
  logic signed [PROD_W-1:0] px_nxt, py_nxt, px_r, py_r, qx_sum, qy_sum;
  logic signed [POS_W-1:0] qx, qy;

  logic                    pv_r, end_r;
  logic signed [POS_W-1:0] posx_r, posy_r;
  logic [IDX_W-1:0]        idx_r;

  assign rdy2     = !out_valid_r || !out_stall;
  assign rdy1     = !vb1_r || rdy2;
  assign rdy0     = !vb0_r || rdy1;
  assign up_ready = rdy0;

  always_comb begin
    s = to_q16(up_y);
    c = to_q16(up_x);
    case (up_side.quad)
      2'd0: begin
        sn_nxt = s;
        cs_nxt = c;
      end
      2'd1: begin
        sn_nxt = c;
        cs_nxt = -s;
      end
      2'd2: begin
        sn_nxt = -s;
        cs_nxt = -c;
      end
      default: begin
        sn_nxt = -c;
        cs_nxt = s;
      end
    endcase
  end

  always_comb begin
    dist_s = $signed({1'b0, side0_r.distance});
    px_nxt = PROD_W'(dist_s) * PROD_W'(sn_r);
    py_nxt = PROD_W'(dist_s) * PROD_W'(cs_r);
    // divide by 2^16 truncating toward zero
    qx_sum = px_r + (px_r[PROD_W-1] ? TRUNC_ADJ : '0);
    qy_sum = py_r + (py_r[PROD_W-1] ? TRUNC_ADJ : '0);
    qx     = qx_sum[16 +: POS_W];
    qy     = qy_sum[16 +: POS_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb0_r       <= 1'b0;
      vb1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) vb0_r <= up_valid;
      if (rdy1) vb1_r <= vb0_r;
      if (rdy2) out_valid_r <= vb1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      sn_r    <= sn_nxt;
      cs_r    <= cs_nxt;
      side0_r <= up_side;
    end
    if (rdy1) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      side1_r <= side0_r;
    end
    if (rdy2) begin
      pv_r   <= side1_r.keep;
      end_r  <= side1_r.last;
      posx_r <= side1_r.keep ? -qx : '0;
      posy_r <= side1_r.keep ? qy : '0;
      idx_r  <= side1_r.keep ? side1_r.index : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_valid = pv_r;
  assign out_pos_x       = posx_r;
  assign out_pos_y       = posy_r;
  assign out_point_index = idx_r;
  assign out_scan_end    = end_r;

endmodule

`default_nettype wire

// ===== sv/lidar_polar_to_cartesian_top.sv =====
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_top
// lidar sample to cartesian point converter with a pipelined cordic
// ----------------------------------------------------------------------------
// Takes one sample per clock while out_stall is low, gives one result item per
// sample, in order, through 4 front stages (point counter, quadrant split,
// remainder to radians), a chain of 24 cordic cells, and 3 back stages (q16
// rounding and quadrant map, distance multiply, output register). Every stage
// has its own valid bit and loads whenever its successor can move, so bubbles
// close up and a stall on out_stall reaches in_stall only once all stages are
// full. Samples with zero distance, or beyond MAX_POINTS kept points in a
// scan, come out with out_point_valid low and zero coordinates and index. The
// point index restarts after an item with in_last_in_scan set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_polar_to_cartesian_top_assert.svh"

module lidar_polar_to_cartesian_top #(
  parameter int MAX_POINTS = lp2c_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lp2c_pkg::DIST_W-1:0]       in_distance,
  input  logic [lp2c_pkg::ANG_W-1:0]        in_angle,
  input  logic                              in_last_in_scan,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_point_valid,
  output logic signed [lp2c_pkg::POS_W-1:0] out_pos_x,
  output logic signed [lp2c_pkg::POS_W-1:0] out_pos_y,
  output logic [lp2c_pkg::IDX_W-1:0]        out_point_index,
  output logic                              out_scan_end
);
  import lp2c_pkg::*;

  localparam logic signed [XY_W-1:0] X_INIT = $signed(XY_W'(GAIN_INV));

  logic                   valid_w [CORDIC_STEPS+1];
  logic                   ready_w [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x_w     [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_w     [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_w     [CORDIC_STEPS+1];
  side_t                  side_w  [CORDIC_STEPS+1];

  lp2c_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_distance    (in_distance),
    .in_angle       (in_angle),
    .in_last_in_scan(in_last_in_scan),
    .dn_valid       (valid_w[0]),
    .dn_ready       (ready_w[0]),
    .dn_z           (z_w[0]),
    .dn_side        (side_w[0])
  );

  assign x_w[0] = X_INIT;
  assign y_w[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lp2c_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(valid_w[i]),
      .up_ready(ready_w[i]),
      .up_x    (x_w[i]),
      .up_y    (y_w[i]),
      .up_z    (z_w[i]),
      .up_side (side_w[i]),
      .dn_valid(valid_w[i+1]),
      .dn_ready(ready_w[i+1]),
      .dn_x    (x_w[i+1]),
      .dn_y    (y_w[i+1]),
      .dn_z    (z_w[i+1]),
      .dn_side (side_w[i+1])
    );
  end

  lp2c_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (valid_w[CORDIC_STEPS]),
    .up_ready       (ready_w[CORDIC_STEPS]),
    .up_x           (x_w[CORDIC_STEPS]),
    .up_y           (y_w[CORDIC_STEPS]),
    .up_side        (side_w[CORDIC_STEPS]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_valid(out_point_valid),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_point_index(out_point_index),
    .out_scan_end   (out_scan_end)
  );

  // the final angle residue feeds only the residue assertion beyond the last cell
  logic z_last_sign;
  logic out_all_zero;
  logic residue_small;
  assign z_last_sign   = z_w[CORDIC_STEPS][Z_W-1];
  assign out_all_zero  = out_pos_x == '0 && out_pos_y == '0 && out_point_index == '0;
  assign residue_small = z_w[CORDIC_STEPS] > -$signed(Z_W'(256));

  `LP2C_ASSERT_IMPL(a_drop_zero, out_valid && !out_point_valid, out_all_zero)
  `LP2C_ASSERT_IMPL(a_residue_small, valid_w[CORDIC_STEPS] && z_last_sign, residue_small)

endmodule

`default_nettype wire
